>>> rtl/core/pcst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the challenge session table core.
// No dependencies; used by the core and the testbench.
package pcst_pkg;

   // Per-entry bookkeeping word held in the metadata memory
   typedef struct packed {
      logic [63:0] key;
      logic [15:0] count;
      logic [31:0] created;
      logic        solved;
      logic [31:0] owner;
   } meta_type;

   localparam int META_W  = $bits(meta_type);
   localparam int BYTES_W = 256;

   // Decision codes
   localparam logic [1:0] DEC_PASS  = 2'd0;
   localparam logic [1:0] DEC_NEW   = 2'd1;
   localparam logic [1:0] DEC_PAGE  = 2'd2;
   localparam logic [1:0] DEC_FULL  = 2'd3;

   // Answer check codes
   localparam logic [2:0] CHK_NONE    = 3'd0;
   localparam logic [2:0] CHK_SOLVED  = 3'd1;
   localparam logic [2:0] CHK_REUSE   = 3'd2;
   localparam logic [2:0] CHK_UNKNOWN = 3'd3;
   localparam logic [2:0] CHK_REJECT  = 3'd4;
   localparam logic [2:0] CHK_WRONG   = 3'd5;

   // Register indexes
   localparam logic [1:0] REG_ENABLE    = 2'd0;
   localparam logic [1:0] REG_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_EXPIRE    = 2'd2;
   localparam logic [1:0] REG_MAX_USAGE = 2'd3;

   // Reset values of the registers
   localparam logic [31:0] RST_THRESHOLD = 32'h0000_FFFF;
   localparam logic [19:0] RST_EXPIRE    = 20'd600;
   localparam logic [15:0] RST_MAX_USAGE = 16'd400;

   // SHA-256 initial hash words
   localparam logic [31:0] IV0 = 32'h6a09e667;
   localparam logic [31:0] IV1 = 32'hbb67ae85;
   localparam logic [31:0] IV2 = 32'h3c6ef372;
   localparam logic [31:0] IV3 = 32'ha54ff53a;
   localparam logic [31:0] IV4 = 32'h510e527f;
   localparam logic [31:0] IV5 = 32'h9b05688c;
   localparam logic [31:0] IV6 = 32'h1f83d9ab;
   localparam logic [31:0] IV7 = 32'h5be0cd19;

   // Padding words for a 36-byte message
   localparam logic [31:0] PAD_WORD = 32'h8000_0000;
   localparam logic [31:0] LEN_WORD = 32'h0000_0120;

   function automatic logic [31:0] bswap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   // SHA-256 round constants
   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      unique case (i)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

>>> rtl/core/pcst_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pcst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/pow_challenge_session_table_core.sv
`timescale 1ns / 1ps
// Challenge session table core: set-associative lookup, SHA-256 answer check, issue.
// Depends on pcst_pkg and pcst_ram.
//
// Channel | Direction | Contents
// req_    | in        | tuser {has_challenge, has_answer, has_id}; tdata request fields
// rsp_    | out       | tdata {check_result, decision}
// csr_    | in        | csr_index register number, csr_data write value
//
// A request passes through accept, set reduction and completion, plus a read state and a
// check state per way scanned (one memory read each) in the lookup and in the issue scan,
// plus the SHA-256 round unit when an unsolved entry is checked.
// After reset a clearing pass writes every metadata entry before the first request is
// taken; register writes are taken at any time.
// A finished result waits in the output register; the next request is taken meanwhile
// and stalls only at its own end if the previous result is still not taken.
module pow_challenge_session_table_core #(
   parameter int SETS = 1024,
   parameter int WAYS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [63:0] presented_id, [95:64] answer, [127:96] client_ip, [159:128] now_seconds,
   // [223:160] fresh_id, [287:224] fresh_word0, [351:288] fresh_word1,
   // [415:352] fresh_word2, [479:416] fresh_word3
   input  logic [479:0] req_tdata,
   // [0] has_id, [1] has_answer, [2] has_challenge
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] decision, [4:2] check_result, [7:5] zero
   output logic [7:0]   rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import pcst_pkg::*;

   // Residues of 2^(8i) modulo SETS for the eight id bytes
   function automatic logic [135:0] res_table();
      logic [135:0]    tbl;
      longint unsigned p;
      tbl = '0;
      p = 64'd1 % 64'(SETS);
      for (int i = 0; i < 8; i++) begin
         tbl[17*i +: 17] = 17'(p);
         p = (p * 64'd256) % 64'(SETS);
      end
      return tbl;
   endfunction

   localparam int ENTRIES = SETS * WAYS;
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RW = ((SETS > 1) ? $clog2(SETS) : 0) + 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [135:0] RES_TABLE = res_table();
   localparam logic [32:0]  RECIP     = 33'((64'd1 << 32) / 64'(SETS));

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MOD   = 4'd2;
   localparam logic [3:0] S_LRD   = 4'd3;
   localparam logic [3:0] S_LCHK  = 4'd4;
   localparam logic [3:0] S_HASH  = 4'd5;
   localparam logic [3:0] S_HFIN  = 4'd6;
   localparam logic [3:0] S_ARD   = 4'd7;
   localparam logic [3:0] S_ACHK  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction
   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction
   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b0, x[31:3]};
   endfunction
   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   // Control and configuration state
   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [WW-1:0] way_ff, way_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          enable_ff, enable_in;
   logic [31:0]   thresh_ff, thresh_in;
   logic [19:0]   expire_ff, expire_in;
   logic [15:0]   max_use_ff, max_use_in;

   // Payload state
   logic [63:0]   pid_ff, pid_in;
   logic [31:0]   ans_ff, ans_in;
   logic [31:0]   ip_ff, ip_in;
   logic [31:0]   now_ff, now_in;
   logic [63:0]   fid_ff, fid_in;
   logic [255:0]  chal_ff, chal_in;
   logic [2:0]    flags_ff, flags_in;
   logic [63:0]   id_sh_ff, id_sh_in;
   logic [63:0]   fid_sh_ff, fid_sh_in;
   logic [27:0]   iacc_ff, iacc_in;
   logic [27:0]   facc_ff, facc_in;
   logic [27:0]   iquo_ff, iquo_in;
   logic [27:0]   fquo_ff, fquo_in;
   logic [RW-1:0] iset_ff, iset_in;
   logic [RW-1:0] fset_ff, fset_in;
   meta_type      found_ff, found_in;
   logic [1:0]    dec_ff, dec_in;
   logic [2:0]    chk_ff, chk_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic [31:0]   w_ff [16];
   logic [31:0]   w_in [16];
   logic [31:0]   va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff, vh_ff;
   logic [31:0]   va_in, vb_in, vc_in, vd_in, ve_in, vf_in, vg_in, vh_in;

   // Memory ports
   logic                m_we, b_we;
   logic [AW-1:0]       m_waddr, cur_addr;
   logic [META_W-1:0]   m_wdata, m_rdata;
   logic [BYTES_W-1:0]  b_rdata;
   meta_type            md, m_wmeta;

   logic                id_ok;
   logic [RW-1:0]       set_sel;
   logic [16:0]         res_cur;
   logic [24:0]         iprod, fprod;
   logic [60:0]         irecip, frecip;
   logic [27:0]         irem, frem, ifin, ffin;
   logic [15:0]         cnt_new;
   logic [31:0]         t1, t2, w_new, h0_le;

   assign md      = meta_type'(m_rdata);
   assign m_wdata = META_W'(m_wmeta);
   assign id_ok   = flags_ff[0] && (pid_ff != 64'd0);
   assign set_sel = (state_ff == S_ARD || state_ff == S_ACHK) ? fset_ff : iset_ff;
   assign cur_addr = AW'(set_sel) * AW'(WAYS) + AW'(way_ff);
   assign cnt_new  = (md.count == 16'hFFFF) ? md.count : md.count + 16'd1;

   // Set reduction: fold the id bytes by their residues, then divide by reciprocal
   assign res_cur = RES_TABLE[17*cnt_ff[2:0] +: 17];
   assign iprod   = 25'(id_sh_ff[7:0]) * 25'(res_cur);
   assign fprod   = 25'(fid_sh_ff[7:0]) * 25'(res_cur);
   assign irecip  = 61'(iacc_ff) * 61'(RECIP);
   assign frecip  = 61'(facc_ff) * 61'(RECIP);
   assign irem    = iacc_ff - iquo_ff * 28'(SETS);
   assign frem    = facc_ff - fquo_ff * 28'(SETS);
   assign ifin    = (iacc_ff >= 28'(SETS)) ? iacc_ff - 28'(SETS) : iacc_ff;
   assign ffin    = (facc_ff >= 28'(SETS)) ? facc_ff - 28'(SETS) : facc_ff;

   // One SHA-256 round and message schedule step
   assign t1 = vh_ff + bsig1(ve_ff) + ((ve_ff & vf_ff) ^ (~ve_ff & vg_ff))
             + round_k(cnt_ff) + w_ff[0];
   assign t2 = bsig0(va_ff) + ((va_ff & vb_ff) ^ (va_ff & vc_ff) ^ (vb_ff & vc_ff));
   assign w_new = w_ff[0] + ssig0(w_ff[1]) + w_ff[9] + ssig1(w_ff[14]);
   assign h0_le = bswap32(IV0 + va_ff);

   // Next-state logic
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cnt_in      = cnt_ff;
      way_in      = way_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      enable_in   = enable_ff;
      thresh_in   = thresh_ff;
      expire_in   = expire_ff;
      max_use_in  = max_use_ff;
      pid_in   = pid_ff;
      ans_in   = ans_ff;
      ip_in    = ip_ff;
      now_in   = now_ff;
      fid_in   = fid_ff;
      chal_in  = chal_ff;
      flags_in = flags_ff;
      id_sh_in = id_sh_ff;
      fid_sh_in = fid_sh_ff;
      iacc_in  = iacc_ff;
      facc_in  = facc_ff;
      iquo_in  = iquo_ff;
      fquo_in  = fquo_ff;
      iset_in  = iset_ff;
      fset_in  = fset_ff;
      found_in = found_ff;
      dec_in   = dec_ff;
      chk_in   = chk_ff;
      w_in     = w_ff;
      va_in = va_ff; vb_in = vb_ff; vc_in = vc_ff; vd_in = vd_ff;
      ve_in = ve_ff; vf_in = vf_ff; vg_in = vg_ff; vh_in = vh_ff;
      m_we    = 1'b0;
      b_we    = 1'b0;
      m_waddr = cur_addr;
      m_wmeta = md;

      // Register writes
      if (csr_valid) begin
         unique case (csr_index)
            REG_ENABLE:    enable_in  = csr_data[0];
            REG_THRESHOLD: thresh_in  = csr_data;
            REG_EXPIRE:    expire_in  = csr_data[19:0];
            REG_MAX_USAGE: max_use_in = csr_data[15:0];
            default:       enable_in  = enable_ff;
         endcase
      end

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            m_we    = 1'b1;
            m_waddr = clr_addr_ff;
            m_wmeta = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               flags_in  = req_tuser;
               pid_in    = req_tdata[63:0];
               ans_in    = req_tdata[95:64];
               ip_in     = req_tdata[127:96];
               now_in    = req_tdata[159:128];
               fid_in    = req_tdata[223:160];
               chal_in   = req_tdata[479:224];
               id_sh_in  = req_tdata[63:0];
               fid_sh_in = req_tdata[223:160];
               iacc_in   = '0;
               facc_in   = '0;
               cnt_in    = '0;
               chk_in    = CHK_NONE;
               state_in  = S_MOD;
            end
         end
         S_MOD: begin
            cnt_in = cnt_ff + 6'd1;
            way_in = '0;
            if (cnt_ff < 6'd8) begin
               // Accumulate one byte of each id per cycle
               iacc_in   = iacc_ff + 28'(iprod);
               facc_in   = facc_ff + 28'(fprod);
               id_sh_in  = {8'd0, id_sh_ff[63:8]};
               fid_sh_in = {8'd0, fid_sh_ff[63:8]};
            end else if (cnt_ff == 6'd8) begin
               iquo_in = irecip[59:32];
               fquo_in = frecip[59:32];
            end else if (cnt_ff == 6'd9) begin
               iacc_in = irem;
               facc_in = frem;
            end else begin
               iset_in = RW'(ifin);
               fset_in = RW'(ffin);
               if (id_ok && flags_ff[1]) begin
                  state_in = S_LRD;
               end else if (!enable_ff) begin
                  dec_in   = DEC_PASS;
                  state_in = S_DONE;
               end else if (id_ok && flags_ff[2]) begin
                  dec_in   = DEC_PAGE;
                  state_in = S_DONE;
               end else begin
                  state_in = S_ARD;
               end
            end
         end
         S_LRD: begin
            state_in = S_LCHK;
         end
         S_LCHK: begin
            // Failed checks fall through to issue, or to a pass when disabled; overridden on success
            way_in = '0;
            if (enable_ff) begin
               state_in = S_ARD;
            end else begin
               dec_in   = DEC_PASS;
               state_in = S_DONE;
            end
            if (md.key == 64'd0) begin
               chk_in = CHK_UNKNOWN;
            end else if (md.key == pid_ff) begin
               if (md.solved) begin
                  if (md.owner != ip_ff) begin
                     chk_in = CHK_REJECT;
                  end else if (cnt_new >= max_use_ff ||
                               (now_ff - md.created) > {12'd0, expire_ff}) begin
                     m_we    = 1'b1;
                     m_wmeta = '0;
                     chk_in  = CHK_REJECT;
                  end else begin
                     m_we          = 1'b1;
                     m_wmeta.count = cnt_new;
                     chk_in        = CHK_REUSE;
                     dec_in        = DEC_PASS;
                     state_in      = S_DONE;
                  end
               end else begin
                  // Load the message block and start the hash
                  found_in = md;
                  way_in   = way_ff;
                  for (int j = 0; j < 8; j++) begin
                     w_in[j] = bswap32(b_rdata[32*j +: 32]);
                  end
                  w_in[8] = bswap32(ans_ff);
                  w_in[9] = PAD_WORD;
                  for (int j = 10; j < 15; j++) begin
                     w_in[j] = '0;
                  end
                  w_in[15] = LEN_WORD;
                  va_in = IV0; vb_in = IV1; vc_in = IV2; vd_in = IV3;
                  ve_in = IV4; vf_in = IV5; vg_in = IV6; vh_in = IV7;
                  cnt_in   = '0;
                  state_in = S_HASH;
               end
            end else if (way_ff == WW'(WAYS - 1)) begin
               chk_in = CHK_UNKNOWN;
            end else begin
               way_in   = way_ff + WW'(1);
               state_in = S_LRD;
            end
         end
         S_HASH: begin
            vh_in = vg_ff; vg_in = vf_ff; vf_in = ve_ff; ve_in = vd_ff + t1;
            vd_in = vc_ff; vc_in = vb_ff; vb_in = va_ff; va_in = t1 + t2;
            for (int j = 0; j < 15; j++) begin
               w_in[j] = w_ff[j + 1];
            end
            w_in[15] = w_new;
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = S_HFIN;
            end
         end
         S_HFIN: begin
            if (h0_le <= thresh_ff) begin
               m_we           = 1'b1;
               m_wmeta        = found_ff;
               m_wmeta.solved = 1'b1;
               chk_in         = CHK_SOLVED;
               dec_in         = DEC_PASS;
               state_in       = S_DONE;
            end else begin
               chk_in = CHK_WRONG;
               way_in = '0;
               if (enable_ff) begin
                  state_in = S_ARD;
               end else begin
                  dec_in   = DEC_PASS;
                  state_in = S_DONE;
               end
            end
         end
         S_ARD: begin
            state_in = S_ACHK;
         end
         S_ACHK: begin
            if (md.key == 64'd0 || (now_ff - md.created) > {12'd0, expire_ff}) begin
               m_we            = 1'b1;
               b_we            = 1'b1;
               m_wmeta.key     = fid_ff;
               m_wmeta.count   = '0;
               m_wmeta.created = now_ff;
               m_wmeta.solved  = 1'b0;
               m_wmeta.owner   = ip_ff;
               dec_in          = DEC_NEW;
               state_in        = S_DONE;
            end else if (way_ff == WW'(WAYS - 1)) begin
               dec_in   = DEC_FULL;
               state_in = S_DONE;
            end else begin
               way_in   = way_ff + WW'(1);
               state_in = S_ARD;
            end
         end
         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'd0, chk_ff, dec_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         cnt_ff       <= '0;
         way_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b1;
         thresh_ff    <= RST_THRESHOLD;
         expire_ff    <= RST_EXPIRE;
         max_use_ff   <= RST_MAX_USAGE;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cnt_ff       <= cnt_in;
         way_ff       <= way_in;
         rsp_valid_ff <= rsp_valid_in;
         enable_ff    <= enable_in;
         thresh_ff    <= thresh_in;
         expire_ff    <= expire_in;
         max_use_ff   <= max_use_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pid_ff <= pid_in;
      ans_ff <= ans_in;
      ip_ff <= ip_in;
      now_ff <= now_in;
      fid_ff <= fid_in;
      chal_ff <= chal_in;
      flags_ff <= flags_in;
      id_sh_ff <= id_sh_in;
      fid_sh_ff <= fid_sh_in;
      iacc_ff <= iacc_in;
      facc_ff <= facc_in;
      iquo_ff <= iquo_in;
      fquo_ff <= fquo_in;
      iset_ff <= iset_in;
      fset_ff <= fset_in;
      found_ff <= found_in;
      dec_ff <= dec_in;
      chk_ff <= chk_in;
      rsp_data_ff <= rsp_data_in;
      w_ff <= w_in;
      va_ff <= va_in; vb_ff <= vb_in; vc_ff <= vc_in; vd_ff <= vd_in;
      ve_ff <= ve_in; vf_ff <= vf_in; vg_ff <= vg_in; vh_ff <= vh_in;
   end

   // Entry metadata: key, use count, creation time, solved, owner
   pcst_ram #(.WIDTH(META_W), .DEPTH(ENTRIES)) u_meta_ram (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_waddr),
      .wr_data (m_wdata),
      .rd_addr (cur_addr),
      .rd_data (m_rdata)
   );

   // Challenge bytes, written only when a challenge is issued
   pcst_ram #(.WIDTH(BYTES_W), .DEPTH(ENTRIES)) u_bytes_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (cur_addr),
      .wr_data (chal_ff),
      .rd_addr (cur_addr),
      .rd_data (b_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // No table update while the round unit runs
   a_no_write_in_hash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HASH) |-> !m_we && !b_we)
      else $error("table written during hash");

   // No request taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("request taken while clearing");

   // A result appears only from the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result without completion");

   // Challenge bytes are written only together with a fresh key
   a_bytes_with_key: assert property (@(posedge clock) disable iff (reset)
      b_we |-> m_we && (state_ff == S_ACHK))
      else $error("challenge bytes written alone");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the challenge session table core: stream driver and monitor,
// an in-bench table model with its own SHA-256, and phased register settings.
// Depends on pcst_pkg and the core RTL.
module tb_top;
   import pcst_pkg::*;

   localparam int NSETS   = 1024;
   localparam int NWAYS   = 4;
   localparam int NSLOTS  = NSETS * NWAYS;
   localparam int PHASE_N = 300;

   typedef struct {
      logic        has_id;
      logic [63:0] pid;
      logic        has_ans;
      logic [31:0] ans;
      logic        has_chal;
      logic [31:0] ip;
      logic [31:0] now;
      logic [63:0] fid;
      logic [63:0] cw [4];
   } request_type;

   typedef struct {
      logic [1:0] dec;
      logic [2:0] chk;
   } verdict_type;

   typedef struct {
      logic [63:0] id;
      logic [31:0] ip;
   } ticket_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [479:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   pow_challenge_session_table_core #(.SETS(NSETS), .WAYS(NWAYS)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Model of the table and its registers
   logic        gate_on;
   logic [31:0] hash_limit;
   logic [19:0] max_age;
   logic [15:0] wear_limit;
   logic [63:0] tag_mem   [NSLOTS];
   logic [63:0] chal_mem  [NSLOTS][4];
   logic [15:0] uses_mem  [NSLOTS];
   logic [31:0] born_mem  [NSLOTS];
   logic        solved_mem[NSLOTS];
   logic [31:0] owner_mem [NSLOTS];

   request_type pending_reqs[$];
   verdict_type expected_verdicts[$];
   ticket_type  tickets[$];
   request_type cur_req;
   int       errors = 0;
   int       n_accepted = 0;
   int       n_results = 0;
   int       chk_seen[8];
   int       dec_seen[4];
   int       gap_left = 0;
   int       burst_left = 1;
   int       stall_mode = 0;
   int       stall_tick = 0;
   logic [31:0] clock_sec;
   logic [31:0] ip_pool[4] = '{32'h0, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0A00_0002};
   int          set_pool[6] = '{0, 1023, 5, 77, 512, 300};

   function automatic logic [31:0] rot(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // First digest word (little-endian) of SHA-256 over challenge bytes and nonce
   function automatic logic [31:0] lead_digest_word(logic [63:0] c0, logic [63:0] c1,
                                                    logic [63:0] c2, logic [63:0] c3,
                                                    logic [31:0] nonce);
      logic [31:0] kc [64] = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      logic [7:0]   blk [64];
      logic [31:0]  w [64];
      logic [255:0] msg;
      logic [31:0]  a, b, c, d, e, f, g, h, t1, t2, s0, s1, h0;
      msg = {c3, c2, c1, c0};
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      for (int i = 0; i < 32; i++) blk[i] = msg[8*i +: 8];
      for (int i = 0; i < 4; i++) blk[32+i] = nonce[8*i +: 8];
      blk[36] = 8'h80;
      blk[62] = 8'h01;
      blk[63] = 8'h20;
      for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = rot(w[i-15], 7) ^ rot(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rot(w[i-2], 17) ^ rot(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = 32'h6a09e667; b = 32'hbb67ae85; c = 32'h3c6ef372; d = 32'ha54ff53a;
      e = 32'h510e527f; f = 32'h9b05688c; g = 32'h1f83d9ab; h = 32'h5be0cd19;
      for (int i = 0; i < 64; i++) begin
         t1 = h + (rot(e, 6) ^ rot(e, 11) ^ rot(e, 25)) + ((e & f) ^ (~e & g)) + kc[i] + w[i];
         t2 = (rot(a, 2) ^ rot(a, 13) ^ rot(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      h0 = 32'h6a09e667 + a;
      return {h0[7:0], h0[15:8], h0[23:16], h0[31:24]};
   endfunction

   function automatic logic is_stale(int s, logic [31:0] now);
      logic [31:0] age;
      age = now - born_mem[s];
      return age > {12'h0, max_age};
   endfunction

   // Apply one request to the table model and return its verdict
   function automatic verdict_type serve_request(request_type r);
      verdict_type v;
      logic     id_ok;
      int       base, hit, slot;
      id_ok = r.has_id && (r.pid != 0);
      v.chk = CHK_NONE;
      v.dec = DEC_PASS;
      if (id_ok && r.has_ans) begin
         hit = -1;
         base = int'(r.pid[9:0]) * NWAYS;
         for (int k = 0; k < NWAYS; k++) begin
            if (tag_mem[base+k] == 0) break;
            if (tag_mem[base+k] == r.pid) begin
               hit = base + k;
               break;
            end
         end
         if (hit < 0) v.chk = CHK_UNKNOWN;
         else if (solved_mem[hit]) begin
            if (owner_mem[hit] != r.ip) v.chk = CHK_REJECT;
            else begin
               if (uses_mem[hit] != 16'hFFFF) uses_mem[hit]++;
               if (uses_mem[hit] >= wear_limit || is_stale(hit, r.now)) begin
                  tag_mem[hit] = '0;
                  for (int q = 0; q < 4; q++) chal_mem[hit][q] = '0;
                  uses_mem[hit] = '0;
                  born_mem[hit] = '0;
                  solved_mem[hit] = 1'b0;
                  owner_mem[hit] = '0;
                  v.chk = CHK_REJECT;
               end else v.chk = CHK_REUSE;
            end
         end else if (lead_digest_word(chal_mem[hit][0], chal_mem[hit][1], chal_mem[hit][2],
                                       chal_mem[hit][3], r.ans) <= hash_limit) begin
            solved_mem[hit] = 1'b1;
            v.chk = CHK_SOLVED;
         end else v.chk = CHK_WRONG;
         if (v.chk == CHK_SOLVED || v.chk == CHK_REUSE) return v;
         id_ok = 1'b0;
      end
      if (!gate_on) v.dec = DEC_PASS;
      else if (id_ok && r.has_chal) v.dec = DEC_PAGE;
      else begin
         slot = -1;
         base = int'(r.fid[9:0]) * NWAYS;
         for (int k = 0; k < NWAYS; k++) begin
            if (tag_mem[base+k] == 0 || is_stale(base + k, r.now)) begin
               slot = base + k;
               break;
            end
         end
         if (slot < 0) v.dec = DEC_FULL;
         else begin
            tag_mem[slot] = r.fid;
            for (int q = 0; q < 4; q++) chal_mem[slot][q] = r.cw[q];
            uses_mem[slot] = '0;
            born_mem[slot] = r.now;
            solved_mem[slot] = 1'b0;
            owner_mem[slot] = r.ip;
            v.dec = DEC_NEW;
         end
      end
      return v;
   endfunction

   task automatic report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Driver: bursts of requests separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_verdicts.push_back(serve_request(cur_req));
            n_accepted++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0 || pending_reqs.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               cur_req = pending_reqs.pop_front();
               req_tdata <= {cur_req.cw[3], cur_req.cw[2], cur_req.cw[1], cur_req.cw[0],
                             cur_req.fid, cur_req.now, cur_req.ip, cur_req.ans, cur_req.pid};
               req_tuser <= {cur_req.has_chal, cur_req.has_ans, cur_req.has_id};
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
               end
            end
         end
      end
   end

   // Monitor: compare each result with the oldest prediction; stall per mode
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (expected_verdicts.size() == 0) report("result with nothing expected");
            else begin
               verdict_type v;
               v = expected_verdicts.pop_front();
               chk_seen[v.chk]++;
               dec_seen[v.dec]++;
               if (rsp_tdata[1:0] !== v.dec)
                  report($sformatf("decision %0d, expected %0d", rsp_tdata[1:0], v.dec));
               if (rsp_tdata[4:2] !== v.chk)
                  report($sformatf("check %0d, expected %0d", rsp_tdata[4:2], v.chk));
               if (rsp_tdata[7:5] !== 3'b000) report("nonzero pad bits");
            end
         end
         stall_tick++;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ((stall_tick % 300) > 250);
            default: rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // Write one register, then let the channel go idle before returning
   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (idx)
         REG_ENABLE:    gate_on = val[0];
         REG_THRESHOLD: hash_limit = val;
         REG_EXPIRE:    max_age = val[19:0];
         default:       wear_limit = val[15:0];
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_tvalid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_fid();
      logic [63:0] v;
      v = rand64();
      if ($urandom_range(0, 9) != 0) v[9:0] = 10'(set_pool[$urandom_range(0, 5)]);
      return v;
   endfunction

   function automatic request_type blank_req();
      request_type r;
      r.has_id = 0; r.pid = 0; r.has_ans = 0; r.ans = 0; r.has_chal = 0;
      r.ip = ip_pool[$urandom_range(0, 3)];
      r.now = clock_sec;
      r.fid = pick_fid();
      for (int q = 0; q < 4; q++) r.cw[q] = rand64();
      return r;
   endfunction

   // Challenge issue: remember the id and the address for later answers
   task automatic push_issue(request_type r);
      ticket_type t;
      t.id = r.fid;
      t.ip = r.ip;
      tickets.push_back(t);
      if (tickets.size() > 24) void'(tickets.pop_front());
      pending_reqs.push_back(r);
   endtask

   task automatic push_answer(logic same_ip, logic [31:0] nonce);
      request_type r;
      ticket_type  t;
      r = blank_req();
      if (tickets.size() == 0) begin
         push_issue(r);
         return;
      end
      t = tickets[$urandom_range(0, tickets.size() - 1)];
      r.has_id = 1; r.pid = t.id; r.has_ans = 1; r.ans = nonce;
      r.has_chal = $urandom_range(0, 1);
      if (same_ip) r.ip = t.ip;
      pending_reqs.push_back(r);
   endtask

   task automatic random_phase(int n);
      request_type r;
      int       pick;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) drain();
         pick = $urandom_range(0, 99);
         clock_sec += ($urandom_range(0, 19) == 0) ? $urandom_range(100, 900)
                                                     : $urandom_range(0, 20);
         if (pick < 30) push_issue(blank_req());
         else if (pick < 80) push_answer($urandom_range(0, 7) != 0, $urandom);
         else begin
            r = blank_req();
            r.has_id = $urandom_range(0, 1);
            r.pid = ($urandom_range(0, 1)) ? rand64() : ($urandom_range(0, 1) ? '0 : '1);
            r.has_ans = $urandom_range(0, 1);
            r.ans = $urandom;
            r.has_chal = $urandom_range(0, 1);
            r.ip = $urandom;
            r.now = ($urandom_range(0, 3) == 0) ? $urandom : clock_sec;
            r.fid = ($urandom_range(0, 15) == 0) ? '0 : rand64();
            pending_reqs.push_back(r);
         end
      end
      drain();
   endtask

   initial begin
      request_type r;
      for (int s = 0; s < NSLOTS; s++) begin
         tag_mem[s] = '0; uses_mem[s] = '0; born_mem[s] = '0;
         solved_mem[s] = 1'b0; owner_mem[s] = '0;
         for (int q = 0; q < 4; q++) chal_mem[s][q] = '0;
      end
      gate_on = 1'b1;
      hash_limit = RST_THRESHOLD;
      max_age = RST_EXPIRE;
      wear_limit = RST_MAX_USAGE;
      clock_sec = 32'd1000;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: issue, page only, wrong answer, unknown id, zero ids, all-ones fields, full set
      r = blank_req(); r.fid = 64'h0000_0000_0000_0005; r.ip = 32'hC0A8_0001; push_issue(r);
      r = blank_req(); r.has_id = 1; r.pid = 64'h5; r.has_chal = 1; pending_reqs.push_back(r);
      r = blank_req(); r.has_id = 1; r.pid = 64'h5; r.has_ans = 1; r.ans = '1;
      pending_reqs.push_back(r);
      r = blank_req(); r.has_id = 1; r.pid = '1; r.has_ans = 1; pending_reqs.push_back(r);
      r = blank_req(); r.has_id = 1; r.pid = '0; r.has_ans = 1; pending_reqs.push_back(r);
      r = blank_req(); r.fid = '0; pending_reqs.push_back(r);
      r = blank_req(); r.has_id = 1; r.pid = '1; r.has_ans = 1; r.ans = '1; r.has_chal = 1;
      r.ip = '1; r.now = '1; r.fid = '1;
      for (int q = 0; q < 4; q++) r.cw[q] = '1;
      pending_reqs.push_back(r);
      for (int k = 0; k < 5; k++) begin
         r = blank_req(); r.fid = {54'(k + 1), 10'd9}; pending_reqs.push_back(r);
      end
      drain();

      // Accept every answer: solve, reuse, wrong owner, wear out, expire
      write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
      write_reg(REG_MAX_USAGE, 32'd3);
      r = blank_req(); r.fid = 64'h77; r.ip = 32'h0A00_0002; pending_reqs.push_back(r);
      for (int k = 0; k < 4; k++) begin
         r = blank_req(); r.has_id = 1; r.pid = 64'h77; r.has_ans = 1; r.ip = 32'h0A00_0002;
         r.ans = $urandom; pending_reqs.push_back(r);
         if (k == 1) begin
            r.ip = 32'h0A00_0003; pending_reqs.push_back(r);
         end
      end
      r = blank_req(); r.fid = 64'h78; pending_reqs.push_back(r);
      r = blank_req(); r.has_id = 1; r.pid = 64'h78; r.has_ans = 1; pending_reqs.push_back(r);
      r = blank_req(); r.has_id = 1; r.pid = 64'h78; r.has_ans = 1;
      r.now = clock_sec + 32'd700; pending_reqs.push_back(r);
      drain();

      stall_mode = 1;
      random_phase(PHASE_N);

      write_reg(REG_THRESHOLD, 32'h3FFF_FFFF);
      write_reg(REG_MAX_USAGE, 32'd1);
      write_reg(REG_EXPIRE, 32'd0);
      stall_mode = 2;
      random_phase(PHASE_N);

      // Pass-through with the widest age and use limits; time wraps through zero
      write_reg(REG_ENABLE, 32'd0);
      write_reg(REG_THRESHOLD, 32'h8000_0000);
      write_reg(REG_EXPIRE, 32'h000F_FFFF);
      write_reg(REG_MAX_USAGE, 32'h0000_FFFF);
      clock_sec = 32'hFFFF_FE00;
      stall_mode = 3;
      random_phase(PHASE_N);

      write_reg(REG_ENABLE, 32'd1);
      write_reg(REG_THRESHOLD, 32'd0);
      write_reg(REG_EXPIRE, 32'd50);
      stall_mode = 0;
      random_phase(PHASE_N);

      write_reg(REG_THRESHOLD, 32'h7FFF_FFFF);
      write_reg(REG_EXPIRE, 32'd200);
      write_reg(REG_MAX_USAGE, 32'd5);
      stall_mode = 1;
      random_phase(PHASE_N);

      $display("covered %0d requests: solved %0d, reuse %0d, unknown %0d, rejected %0d, wrong %0d",
               n_accepted, chk_seen[CHK_SOLVED], chk_seen[CHK_REUSE], chk_seen[CHK_UNKNOWN],
               chk_seen[CHK_REJECT], chk_seen[CHK_WRONG]);
      $display("decisions: pass %0d, new %0d, page %0d, full %0d",
               dec_seen[DEC_PASS], dec_seen[DEC_NEW], dec_seen[DEC_PAGE], dec_seen[DEC_FULL]);
      if (errors == 0 && expected_verdicts.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
